// File: design/dfar_pkg.sv
// dfar_pkg: types, codes and constants shared by the fixed-address dns responder
// used by dfar_ctrl, dfar_dpath and dns_fixed_address_responder; depends on nothing
package dfar_pkg;

   localparam int BUFFER_BYTES_DEFAULT = 512;
   localparam int CHUNK_BYTES          = 16;

   // header layout
   localparam int HDR_LEN          = 12;
   localparam int HDR_FLAGS_HI     = 2;
   localparam int HDR_FLAGS_LO     = 3;
   localparam int HDR_QDCOUNT_HI   = 4;
   localparam int HDR_QDCOUNT_LO   = 5;
   localparam int HDR_ANCOUNT_HI   = 6;
   localparam int HDR_ANCOUNT_LO   = 7;
   localparam int QUESTION_TAIL    = 4;

   localparam logic [7:0] FLAGS_HI          = 8'h81;
   localparam logic [7:0] FLAGS_LO_ANSWER   = 8'h80;
   localparam logic [7:0] FLAGS_LO_NXDOMAIN = 8'h03;
   localparam logic [7:0] ANCOUNT_ONE       = 8'h01;
   localparam logic [7:0] NAME_PTR_HI       = 8'hc0;
   localparam logic [7:0] NAME_PTR_LO       = 8'h0c;

   localparam logic [15:0] QTYPE_A    = 16'h0001;
   localparam logic [15:0] QTYPE_AAAA = 16'h001c;
   localparam logic [15:0] QCLASS_IN  = 16'h0001;

   localparam logic [7:0] RDLEN_A    = 8'd4;
   localparam logic [7:0] RDLEN_AAAA = 8'd16;

   localparam int ANSWER_A_BYTES    = 16;
   localparam int ANSWER_AAAA_BYTES = 28;

   // configuration registers
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 64;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IPV4_ADDRESS  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IPV6_UPPER    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IPV6_LOWER    = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ANSWER_TTL    = 2'd3;

   localparam logic [31:0] IPV4_ADDRESS_RESET = 32'h7f00_0001;
   localparam logic [63:0] IPV6_UPPER_RESET   = 64'h0;
   localparam logic [63:0] IPV6_LOWER_RESET   = 64'h1;
   localparam logic [31:0] ANSWER_TTL_RESET   = 32'd600;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [63:0] chunk_upper;
      logic [63:0] chunk_lower;
      logic [4:0]  chunk_bytes;
      logic        reply_last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_RECV,
      ST_CHECK,
      ST_READ,
      ST_FILL,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic store;
      logic clear;
      logic rd;
      logic fill;
      logic next;
   } cmd_type;

   typedef struct packed {
      logic drop;
      logic last_chunk;
   } sts_type;

endpackage

// File: design/dfar_ctrl.sv
// dfar_ctrl: sequencer for receive, check and chunked reply of the dns responder
// depends on dfar_pkg; drives dfar_dpath through cmd_type and reads sts_type
module dfar_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_last,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  dfar_pkg::sts_type sts,
   output dfar_pkg::cmd_type cmd
);

   dfar_pkg::state_type state_ff;
   dfar_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dfar_pkg::ST_RECV;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         dfar_pkg::ST_RECV: begin
            req_stall = 1'b0;
            cmd.store = req_valid;
            if (req_valid && req_last) begin
               state_in = dfar_pkg::ST_CHECK;
            end
         end
         dfar_pkg::ST_CHECK: begin
            if (sts.drop) begin
               cmd.clear = 1'b1;
               state_in  = dfar_pkg::ST_RECV;
            end else begin
               state_in = dfar_pkg::ST_READ;
            end
         end
         dfar_pkg::ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = dfar_pkg::ST_FILL;
         end
         dfar_pkg::ST_FILL: begin
            cmd.fill = 1'b1;
            state_in = dfar_pkg::ST_SEND;
         end
         dfar_pkg::ST_SEND: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (sts.last_chunk) begin
                  cmd.clear = 1'b1;
                  state_in  = dfar_pkg::ST_RECV;
               end else begin
                  cmd.next = 1'b1;
                  state_in = dfar_pkg::ST_READ;
               end
            end
         end
         default: begin
            state_in = dfar_pkg::ST_RECV;
         end
      endcase
   end

   a_send_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dfar_pkg::ST_SEND && rsp_stall) |=> state_ff == dfar_pkg::ST_SEND)
      else $error("stalled beat left the send state");

   a_reply_starts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dfar_pkg::ST_CHECK && !sts.drop) |=> ##2 state_ff == dfar_pkg::ST_SEND)
      else $error("accepted query did not reach the first beat");

endmodule

// File: design/dfar_dpath.sv
// dfar_dpath: packet memory, question parser, configuration registers and chunk builder
// depends on dfar_pkg; controlled by dfar_ctrl through cmd_type
module dfar_dpath #(
   parameter int BUFFER_BYTES = dfar_pkg::BUFFER_BYTES_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  dfar_pkg::req_type                       req_data,
   input  logic                                    csr_wr_en,
   input  logic [dfar_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [dfar_pkg::CSR_DATA_BITS-1:0]      csr_wdata,
   input  dfar_pkg::cmd_type                       cmd,
   output dfar_pkg::sts_type                       sts,
   output dfar_pkg::rsp_type                       rsp_data
);

   localparam int AW   = $clog2(BUFFER_BYTES);
   localparam int CW   = $clog2(BUFFER_BYTES + 1);
   localparam int PW   = $clog2(BUFFER_BYTES + 256);
   localparam int LW   = $clog2(BUFFER_BYTES + dfar_pkg::ANSWER_AAAA_BYTES + 6);
   localparam int SW   = LW + 1;
   localparam int KW   = SW - 4;
   localparam int ROWS = (BUFFER_BYTES + dfar_pkg::CHUNK_BYTES - 1) / dfar_pkg::CHUNK_BYTES;
   localparam int RW   = $clog2(ROWS);

   // packet memory, one 16-byte row per reply chunk
   logic [15:0][7:0] pkt_mem [ROWS];
   logic [15:0][7:0] row_data_ff;
   logic [RW-1:0]    wr_row;
   logic [3:0]       wr_lane;
   logic [RW-1:0]    rd_row;
   logic             mem_we;

   logic [CW-1:0] byte_cnt_ff, byte_cnt_in;
   logic [PW-1:0] nlp_ff, nlp_in;
   logic [AW-1:0] name_end_ff, name_end_in;
   logic          found_ff, found_in;
   logic [2:0]    tail_cnt_ff, tail_cnt_in;
   logic [31:0]   qtq_ff, qtq_in;
   logic [7:0]    qd_hi_ff, qd_hi_in;
   logic [7:0]    qd_lo_ff, qd_lo_in;
   logic [KW-1:0] chunk_ff, chunk_in;

   logic [31:0] ipv4_ff;
   logic [63:0] ipv6_upper_ff;
   logic [63:0] ipv6_lower_ff;
   logic [31:0] ttl_ff;

   dfar_pkg::rsp_type rsp_ff;
   dfar_pkg::rsp_type rsp_in;

   logic [15:0]   qtype;
   logic [15:0]   qclass;
   logic          is_answer;
   logic          is_a;
   logic [SW-1:0] len0;
   logic [SW-1:0] reply_len;
   logic [SW-1:0] off;
   logic [SW-1:0] remain;
   logic [7:0]    ans_byte [dfar_pkg::ANSWER_AAAA_BYTES];
   logic [SW-1:0] lane_pos [16];
   logic [SW-1:0] lane_aidx [16];
   logic [7:0]    lane_byte [16];

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         ipv4_ff       <= dfar_pkg::IPV4_ADDRESS_RESET;
         ipv6_upper_ff <= dfar_pkg::IPV6_UPPER_RESET;
         ipv6_lower_ff <= dfar_pkg::IPV6_LOWER_RESET;
         ttl_ff        <= dfar_pkg::ANSWER_TTL_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            dfar_pkg::CSR_IPV4_ADDRESS: ipv4_ff       <= csr_wdata[31:0];
            dfar_pkg::CSR_IPV6_UPPER:   ipv6_upper_ff <= csr_wdata;
            dfar_pkg::CSR_IPV6_LOWER:   ipv6_lower_ff <= csr_wdata;
            dfar_pkg::CSR_ANSWER_TTL:   ttl_ff        <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // memory
   assign mem_we  = cmd.store && (byte_cnt_ff < CW'(BUFFER_BYTES));
   assign wr_row  = RW'(byte_cnt_ff >> 4);
   assign wr_lane = byte_cnt_ff[3:0];
   assign rd_row  = (chunk_ff < KW'(ROWS)) ? RW'(chunk_ff) : '0;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         pkt_mem[wr_row][wr_lane] <= req_data.in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         row_data_ff <= pkt_mem[rd_row];
      end
   end

   // question parser
   always_comb begin
      byte_cnt_in = byte_cnt_ff;
      nlp_in      = nlp_ff;
      name_end_in = name_end_ff;
      found_in    = found_ff;
      tail_cnt_in = tail_cnt_ff;
      qtq_in      = qtq_ff;
      qd_hi_in    = qd_hi_ff;
      qd_lo_in    = qd_lo_ff;
      chunk_in    = chunk_ff;
      if (cmd.clear) begin
         byte_cnt_in = '0;
         nlp_in      = PW'(dfar_pkg::HDR_LEN);
         name_end_in = '0;
         found_in    = 1'b0;
         tail_cnt_in = '0;
         chunk_in    = '0;
      end else begin
         if (mem_we) begin
            byte_cnt_in = byte_cnt_ff + CW'(1);
            if (!found_ff && (PW'(byte_cnt_ff) == nlp_ff)) begin
               if (req_data.in_byte == 8'h00) begin
                  found_in    = 1'b1;
                  name_end_in = AW'(byte_cnt_ff);
               end else begin
                  nlp_in = nlp_ff + PW'(req_data.in_byte) + PW'(1);
               end
            end
            if (found_ff && (tail_cnt_ff < 3'(dfar_pkg::QUESTION_TAIL))) begin
               qtq_in      = {qtq_ff[23:0], req_data.in_byte};
               tail_cnt_in = tail_cnt_ff + 3'd1;
            end
            if (byte_cnt_ff == CW'(dfar_pkg::HDR_QDCOUNT_HI)) begin
               qd_hi_in = req_data.in_byte;
            end
            if (byte_cnt_ff == CW'(dfar_pkg::HDR_QDCOUNT_LO)) begin
               qd_lo_in = req_data.in_byte;
            end
         end
         if (cmd.next) begin
            chunk_in = chunk_ff + KW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_cnt_ff <= '0;
         nlp_ff      <= PW'(dfar_pkg::HDR_LEN);
         name_end_ff <= '0;
         found_ff    <= 1'b0;
         tail_cnt_ff <= '0;
         chunk_ff    <= '0;
      end else begin
         byte_cnt_ff <= byte_cnt_in;
         nlp_ff      <= nlp_in;
         name_end_ff <= name_end_in;
         found_ff    <= found_in;
         tail_cnt_ff <= tail_cnt_in;
         chunk_ff    <= chunk_in;
      end
   end

   always_ff @(posedge clock) begin
      qtq_ff   <= qtq_in;
      qd_hi_ff <= qd_hi_in;
      qd_lo_ff <= qd_lo_in;
   end

   // packet check and reply sizing
   assign qtype     = qtq_ff[31:16];
   assign qclass    = qtq_ff[15:0];
   assign is_a      = (qtype == dfar_pkg::QTYPE_A);
   assign is_answer = (qclass == dfar_pkg::QCLASS_IN) && (is_a || qtype == dfar_pkg::QTYPE_AAAA);

   assign sts.drop = (byte_cnt_ff < CW'(dfar_pkg::HDR_LEN))
                  || ({qd_hi_ff, qd_lo_ff} == 16'h0000)
                  || !found_ff
                  || (name_end_ff == AW'(dfar_pkg::HDR_LEN))
                  || (tail_cnt_ff != 3'(dfar_pkg::QUESTION_TAIL));

   assign len0      = SW'(name_end_ff) + SW'(dfar_pkg::QUESTION_TAIL + 1);
   assign reply_len = len0 + (!is_answer ? SW'(0)
                            : is_a ? SW'(dfar_pkg::ANSWER_A_BYTES)
                            : SW'(dfar_pkg::ANSWER_AAAA_BYTES));
   assign off       = {chunk_ff, 4'b0000};
   assign remain    = reply_len - off;
   assign sts.last_chunk = (off + SW'(dfar_pkg::CHUNK_BYTES)) >= reply_len;

   // answer record
   always_comb begin
      for (int i = 0; i < dfar_pkg::ANSWER_AAAA_BYTES; i++) begin
         ans_byte[i] = 8'h00;
      end
      ans_byte[0]  = dfar_pkg::NAME_PTR_HI;
      ans_byte[1]  = dfar_pkg::NAME_PTR_LO;
      ans_byte[2]  = qtype[15:8];
      ans_byte[3]  = qtype[7:0];
      ans_byte[4]  = qclass[15:8];
      ans_byte[5]  = qclass[7:0];
      ans_byte[6]  = ttl_ff[31:24];
      ans_byte[7]  = ttl_ff[23:16];
      ans_byte[8]  = ttl_ff[15:8];
      ans_byte[9]  = ttl_ff[7:0];
      ans_byte[10] = 8'h00;
      ans_byte[11] = is_a ? dfar_pkg::RDLEN_A : dfar_pkg::RDLEN_AAAA;
      if (is_a) begin
         for (int i = 0; i < 4; i++) begin
            ans_byte[12 + i] = ipv4_ff[31 - 8 * i -: 8];
         end
      end else begin
         for (int i = 0; i < 8; i++) begin
            ans_byte[12 + i] = ipv6_upper_ff[63 - 8 * i -: 8];
            ans_byte[20 + i] = ipv6_lower_ff[63 - 8 * i -: 8];
         end
      end
   end

   // chunk lanes
   always_comb begin
      for (int j = 0; j < dfar_pkg::CHUNK_BYTES; j++) begin
         lane_pos[j]  = off + SW'(j);
         lane_aidx[j] = lane_pos[j] - len0;
         if (lane_pos[j] < len0) begin
            lane_byte[j] = row_data_ff[j];
            if (chunk_ff == '0) begin
               if (j == dfar_pkg::HDR_FLAGS_HI) begin
                  lane_byte[j] = dfar_pkg::FLAGS_HI;
               end else if (j == dfar_pkg::HDR_FLAGS_LO) begin
                  lane_byte[j] = is_answer ? dfar_pkg::FLAGS_LO_ANSWER
                                           : dfar_pkg::FLAGS_LO_NXDOMAIN;
               end else if (is_answer && j >= dfar_pkg::HDR_ANCOUNT_HI
                            && j < dfar_pkg::HDR_LEN) begin
                  lane_byte[j] = (j == dfar_pkg::HDR_ANCOUNT_LO) ? dfar_pkg::ANCOUNT_ONE
                                                                 : 8'h00;
               end
            end
         end else if (lane_pos[j] < reply_len
                      && lane_aidx[j] < SW'(dfar_pkg::ANSWER_AAAA_BYTES)) begin
            lane_byte[j] = ans_byte[lane_aidx[j][4:0]];
         end else begin
            lane_byte[j] = 8'h00;
         end
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.fill) begin
         for (int j = 0; j < 8; j++) begin
            rsp_in.chunk_upper[63 - 8 * j -: 8] = lane_byte[j];
            rsp_in.chunk_lower[63 - 8 * j -: 8] = lane_byte[j + 8];
         end
         rsp_in.chunk_bytes = (remain > SW'(dfar_pkg::CHUNK_BYTES))
                            ? 5'(dfar_pkg::CHUNK_BYTES) : remain[4:0];
         rsp_in.reply_last  = sts.last_chunk;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

   a_name_end_past_header: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> name_end_ff >= AW'(dfar_pkg::HDR_LEN))
      else $error("name end found inside the header");

   a_tail_after_name: assert property (@(posedge clock) disable iff (reset)
      (tail_cnt_ff != 3'd0) |-> found_ff)
      else $error("question tail captured before the name ended");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      mem_we |=> byte_cnt_ff <= CW'(BUFFER_BYTES))
      else $error("byte count ran past the buffer");

endmodule

// File: design/dns_fixed_address_responder.sv
// dns_fixed_address_responder: top level of the fixed-address dns responder
// depends on dfar_pkg, dfar_ctrl and dfar_dpath
//
// A query arrives one byte per beat on the req channel. After the beat marked
// last the block checks the packet; a dropped packet returns to receive right
// away. A reply goes out as up to 34 beats of 16 bytes, each beat passing
// through the read, fill and send states in turn: read a 16-byte row of the
// packet memory, assemble the chunk, then hand it over, holding in send
// while the rsp side stalls. The packet memory has a single read port. No
// query byte is taken while a packet is checked or its reply is sent. The
// packet memory needs no clearing after reset.
module dns_fixed_address_responder #(
   parameter int BUFFER_BYTES = dfar_pkg::BUFFER_BYTES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  dfar_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output dfar_pkg::rsp_type                   rsp_data,
   input  logic                                csr_wr_en,
   input  logic [dfar_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [dfar_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   dfar_pkg::cmd_type cmd;
   dfar_pkg::sts_type sts;

   dfar_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.in_last),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   dfar_dpath #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule
